@@ rtl/tsp_pkg.sv @@
`timescale 1ns / 1ps
package tsp_pkg;

    localparam int DATA_W    = 8;
    localparam int FIELD_W   = 16;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    // default output queue depth, power of two, at least two
    localparam int OUTQ_DEPTH_DEF = 4;

    localparam logic [FIELD_W-1:0] QUIRK_TYPE_RST = 16'h0013;
    localparam logic [FIELD_W-1:0] QUIRK_LEN_RST  = 16'h0002;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_CLEAN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PARTIAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_QUIRK_EN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_QUIRK_TYPE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_QUIRK_LEN  = 2'd2;

    typedef struct packed {
        logic               quirk_enable;
        logic [FIELD_W-1:0] quirk_type;
        logic [FIELD_W-1:0] quirk_length;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]   item_kind;
        logic [FIELD_W-1:0]  record_type;
        logic [FIELD_W-1:0]  record_length;
        logic [DATA_W-1:0]   value_byte;
        logic                record_end;
        logic [STATUS_W-1:0] end_status;
    } t_result;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result item0;
        t_result item1;
    } t_push;

endpackage

@@ rtl/tsp_in_if.sv @@
`timescale 1ns / 1ps
interface tsp_in_if;
    import tsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              final_byte;

    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

@@ rtl/tsp_out_if.sv @@
`timescale 1ns / 1ps
interface tsp_out_if;
    import tsp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   item_kind;
    logic [FIELD_W-1:0]  record_type;
    logic [FIELD_W-1:0]  record_length;
    logic [DATA_W-1:0]   value_byte;
    logic                record_end;
    logic [STATUS_W-1:0] end_status;

    modport source (output valid, item_kind, record_type, record_length, value_byte,
                    record_end, end_status, input ready);
    modport sink   (input valid, item_kind, record_type, record_length, value_byte,
                    record_end, end_status, output ready);
endinterface

@@ rtl/tsp_regs.sv @@
`timescale 1ns / 1ps
module tsp_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [tsp_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [tsp_pkg::APB_W-1:0]     i_pwdata,
    output logic [tsp_pkg::APB_W-1:0]     o_prdata,
    output tsp_pkg::t_cfg                 o_cfg
);
    import tsp_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx   = i_paddr[PADDR_W-1:2];
    assign wr_en = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quirk_enable <= 1'b1;
            r_cfg.quirk_type   <= QUIRK_TYPE_RST;
            r_cfg.quirk_length <= QUIRK_LEN_RST;
        end else if (wr_en) begin
            case (idx)
                REG_QUIRK_EN:   r_cfg.quirk_enable <= i_pwdata[0];
                REG_QUIRK_TYPE: r_cfg.quirk_type   <= i_pwdata[FIELD_W-1:0];
                REG_QUIRK_LEN:  r_cfg.quirk_length <= i_pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (idx)
            REG_QUIRK_EN:   o_prdata = {{(APB_W-1){1'b0}}, r_cfg.quirk_enable};
            REG_QUIRK_TYPE: o_prdata = {{(APB_W-FIELD_W){1'b0}}, r_cfg.quirk_type};
            REG_QUIRK_LEN:  o_prdata = {{(APB_W-FIELD_W){1'b0}}, r_cfg.quirk_length};
            default:        o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

@@ rtl/tsp_core.sv @@
`timescale 1ns / 1ps
module tsp_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tsp_pkg::t_cfg             i_cfg,
    input  logic                      i_accept,
    input  logic [tsp_pkg::DATA_W-1:0] i_data_byte,
    input  logic                      i_final_byte,
    output tsp_pkg::t_push            o_push
);
    import tsp_pkg::*;

    typedef enum logic [4:0] {
        PH_TYPE_HI = 5'b00001,
        PH_TYPE_LO = 5'b00010,
        PH_LEN_HI  = 5'b00100,
        PH_LEN_LO  = 5'b01000,
        PH_BODY    = 5'b10000
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [FIELD_W-1:0]   r_type, n_type;
    logic [FIELD_W-1:0]   r_len, n_len;
    logic [FIELD_W-1:0]   r_left, n_left;
    logic                 r_skip, n_skip;

    logic [FIELD_W-1:0]   len_full;
    logic [FIELD_W-1:0]   left_dec;
    logic                 quirk_hit;
    logic                 res_v;
    t_result              res;
    t_result              stat;
    logic [STATUS_W-1:0]  status;

    assign len_full  = {r_len[FIELD_W-1:DATA_W], i_data_byte};
    assign quirk_hit = i_cfg.quirk_enable && (r_type == i_cfg.quirk_type) &&
                       (len_full != i_cfg.quirk_length);
    assign left_dec  = (r_left != '0) ? r_left - 1'b1 : '0;

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_left  = r_left;
        n_skip  = r_skip;
        status  = ST_PARTIAL;
        res_v   = 1'b0;
        res     = '0;

        case (r_phase)
            PH_TYPE_LO: begin
                n_type  = {r_type[FIELD_W-1:DATA_W], i_data_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {i_data_byte, {DATA_W{1'b0}}};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = len_full;
                if (quirk_hit) begin
                    n_skip = 1'b1;
                    n_left = i_cfg.quirk_length;
                    status = ST_CLEAN;
                end else begin
                    n_skip            = 1'b0;
                    n_left            = len_full;
                    res_v             = 1'b1;
                    res.item_kind     = KIND_HEADER;
                    res.record_type   = r_type;
                    res.record_length = len_full;
                    res.record_end    = (len_full == '0);
                    status            = (len_full == '0) ? ST_CLEAN : ST_TRUNC;
                end
                n_phase = (n_left == '0) ? PH_TYPE_HI : PH_BODY;
            end
            PH_BODY: begin
                n_left = left_dec;
                if (r_skip) begin
                    status = ST_CLEAN;
                end else begin
                    res_v             = 1'b1;
                    res.item_kind     = KIND_VALUE;
                    res.record_type   = r_type;
                    res.record_length = r_len;
                    res.value_byte    = i_data_byte;
                    res.record_end    = (left_dec == '0);
                    status            = (left_dec == '0) ? ST_CLEAN : ST_TRUNC;
                end
                if (left_dec == '0) begin
                    n_phase = PH_TYPE_HI;
                    n_skip  = 1'b0;
                end
            end
            default: begin
                // expecting type high byte; stray codes restart here too
                n_type  = {i_data_byte, {DATA_W{1'b0}}};
                n_phase = PH_TYPE_LO;
            end
        endcase

        if (i_final_byte) begin
            n_phase = PH_TYPE_HI;
            n_type  = '0;
            n_len   = '0;
            n_left  = '0;
            n_skip  = 1'b0;
        end
    end

    always_comb begin
        stat            = '0;
        stat.item_kind  = KIND_STATUS;
        stat.record_end = 1'b1;
        stat.end_status = status;

        o_push.push0 = i_accept && (res_v || i_final_byte);
        o_push.push1 = i_accept && res_v && i_final_byte;
        o_push.item0 = res_v ? res : stat;
        o_push.item1 = stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE_HI;
            r_type  <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_skip  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_left  <= n_left;
            r_skip  <= n_skip;
        end
    end
endmodule

@@ rtl/tsp_outq.sv @@
`timescale 1ns / 1ps
module tsp_outq #(
    parameter int DEPTH = tsp_pkg::OUTQ_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tsp_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output tsp_pkg::t_result o_item
);
    import tsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    t_result              r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr, n_wr;
    logic [PTR_W-1:0]     r_rd, n_rd;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 pop;
    logic [PTR_W-1:0]     wr_nxt;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= ROOM_MAX);
    assign pop     = o_valid & i_ready;
    assign wr_nxt  = r_wr + 1'b1;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.push0) + PTR_W'(i_push.push1);
        n_rd  = r_rd + PTR_W'(pop);
        n_cnt = r_cnt + CNT_W'(i_push.push0) + CNT_W'(i_push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.item0;
        end
        if (i_push.push1) begin
            r_mem[wr_nxt] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end
endmodule

@@ rtl/tlv_stream_parser.sv @@
`timescale 1ns / 1ps
// Streaming TLV record parser, one byte per clock while s_in.ready is set.
// Input channel s_in: data_byte plus final_byte, which flags the buffer's
// last byte. Each record is a 16-bit big-endian type, a 16-bit big-endian
// length and that many value bytes.
// Output channel m_out: one word per result: a header on the fourth header
// byte, one value word per body byte, and an end-status word after the
// final byte's other result. record_end marks a record's last word.
// Records of the quirk type with a wrong length are skipped silently.
// A result is registered in the output queue before it is offered.
// A byte yields at most two words, which drain one per cycle through the
// output queue while m_out.ready is high; s_in.ready drops while the
// queue has fewer than two free slots.
// A stalled receiver holds the head word steady; the queue decouples the
// two sides: the parser takes bytes until fewer than two slots are free.
// Reset (synchronous, active low) empties the queue, returns the parser to
// the type-high phase and loads the quirk registers with their defaults.
// APB registers: 0x0 quirk_enable, 0x4 quirk_type, 0x8 quirk_length.
module tlv_stream_parser #(
    parameter int OUTQ_DEPTH = tsp_pkg::OUTQ_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tsp_in_if.sink                      s_in,
    tsp_out_if.source                   m_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsp_pkg::PADDR_W-1:0] paddr,
    input  logic [tsp_pkg::APB_W-1:0]   pwdata,
    output logic [tsp_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);
    import tsp_pkg::*;

    t_cfg    cfg;
    t_push   push;
    t_result head;
    logic    room;
    logic    in_accept;

    assign pready    = 1'b1;
    assign s_in.ready = room;
    assign in_accept = s_in.valid & room;

    tsp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // parse state and result formation for the accepted byte
    tsp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_accept     (in_accept),
        .i_data_byte  (s_in.data_byte),
        .i_final_byte (s_in.final_byte),
        .o_push       (push)
    );

    // results land here; the queue entries are the result registers
    tsp_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_out.valid),
        .i_ready (m_out.ready),
        .o_item  (head)
    );

    assign m_out.item_kind     = head.item_kind;
    assign m_out.record_type   = head.record_type;
    assign m_out.record_length = head.record_length;
    assign m_out.value_byte    = head.value_byte;
    assign m_out.record_end    = head.record_end;
    assign m_out.end_status    = head.end_status;
endmodule

@@ rtl/tsp_checker.sv @@
`timescale 1ns / 1ps
module tsp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [tsp_pkg::KIND_W-1:0]   i_item_kind,
    input logic [tsp_pkg::FIELD_W-1:0]  i_record_type,
    input logic [tsp_pkg::FIELD_W-1:0]  i_record_length,
    input logic [tsp_pkg::DATA_W-1:0]   i_value_byte,
    input logic                         i_record_end,
    input logic [tsp_pkg::STATUS_W-1:0] i_end_status
);
    import tsp_pkg::*;

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_item_kind) &&
        $stable(i_record_type) && $stable(i_record_length) &&
        $stable(i_value_byte) && $stable(i_record_end) && $stable(i_end_status))
        else $error("output word changed while stalled");

    // after reset the queue is empty and bytes are taken
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("queue not empty after reset");

    // status fields only on status words, which always close
    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_item_kind == KIND_STATUS) ?
            (i_record_end && i_record_type == '0 && i_record_length == '0) :
            (i_end_status == ST_CLEAN &&
             (i_item_kind == KIND_HEADER || i_item_kind == KIND_VALUE)))
        else $error("malformed status or record word");

    // value words belong to a record of nonzero length
    a_value_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_item_kind == KIND_VALUE |-> i_record_length != '0)
        else $error("value word in zero-length record");
endmodule

bind tlv_stream_parser tsp_checker u_tsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (s_in.ready),
    .i_out_valid     (m_out.valid),
    .i_out_ready     (m_out.ready),
    .i_item_kind     (m_out.item_kind),
    .i_record_type   (m_out.record_type),
    .i_record_length (m_out.record_length),
    .i_value_byte    (m_out.value_byte),
    .i_record_end    (m_out.record_end),
    .i_end_status    (m_out.end_status)
);
